FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the converter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/dhtc_pkg.sv
// ----------------------------------------------------------------------------
// dhtc_pkg
// Types, constants and helper functions of the decimal/hex text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhtc_pkg;

    // Default sizes.
    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_CHARS_DEF  = 32;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Per-token flags handed from front to back.
    typedef struct packed {
        logic hex;
        logic err;
    } t_tok_flags;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_PRE0,
        B_PREX,
        B_CONV,
        B_SKIP,
        B_EMIT
    } t_bstate;

    // Digit value of a character; bit 4 flags an invalid digit (value zero).
    function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
        logic [4:0] res;
        res = {1'b1, 4'd0};
        if (c >= CH_ZERO && c <= CH_NINE) begin
            res = {1'b0, 4'(c - CH_ZERO)};
        end else if (hex && c >= CH_LA && c <= CH_LF) begin
            res = {1'b0, 4'(c - CH_LA + 8'd10)};
        end else if (hex && c >= CH_UA && c <= CH_UF) begin
            res = {1'b0, 4'(c - CH_UA + 8'd10)};
        end
        return res;
    endfunction

    // ASCII character of one digit, uppercase above nine.
    function automatic logic [7:0] nib_char(input logic [3:0] n);
        logic [7:0] res;
        if (n < 4'd10) begin
            res = CH_ZERO + {4'd0, n};
        end else begin
            res = CH_UA + {4'd0, n} - 8'd10;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dhtc_front.sv
// ----------------------------------------------------------------------------
// dhtc_front
// Accepts token characters, detects the base and accumulates the value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhtc_front #(
    parameter int VALUE_BITS = dhtc_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = dhtc_pkg::MAX_CHARS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [7:0]              i_char,
    input  wire logic                    i_last,
    input  wire dhtc_pkg::t_q_stat       i_q_stat,
    output logic                         o_ready,
    output logic                         o_push,
    output logic [VALUE_BITS-1:0]        o_value,
    output dhtc_pkg::t_tok_flags         o_flags
);

    localparam int PW = $clog2(MAX_CHARS + 1);

    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [PW-1:0]         r_pos, n_pos;
    logic                  r_hex, n_hex;
    logic                  r_err, n_err;
    logic [4:0]            dv;
    logic                  accept;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign dv      = dhtc_pkg::digit_val(i_char, r_hex);

    // Value update for one character; the prefix 'x' restarts in hex mode.
    always_comb begin
        n_value = r_value;
        n_pos   = r_pos;
        n_hex   = r_hex;
        n_err   = r_err;
        if (r_pos < PW'(MAX_CHARS)) begin
            if (r_pos == PW'(1) && i_char == dhtc_pkg::CH_X) begin
                n_hex   = 1'b1;
                n_value = '0;
                n_err   = 1'b0;
            end else begin
                if (dv[4]) begin
                    n_err = 1'b1;
                end
                if (r_hex) begin
                    n_value = {r_value[VALUE_BITS-5:0], dv[3:0]};
                end else begin
                    n_value = (r_value << 3) + (r_value << 1)
                            + VALUE_BITS'(dv[3:0]);
                end
            end
            n_pos = r_pos + PW'(1);
        end
    end

    // The finished token goes to the queue with the updated state.
    assign o_push        = accept && i_last;
    assign o_value       = n_value;
    assign o_flags.hex   = n_hex;
    assign o_flags.err   = n_err;

    // Token state; cleared after the last character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_pos   <= '0;
            r_hex   <= 1'b0;
            r_err   <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_value <= '0;
                r_pos   <= '0;
                r_hex   <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                r_value <= n_value;
                r_pos   <= n_pos;
                r_hex   <= n_hex;
                r_err   <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/dhtc_fifo.sv
// ----------------------------------------------------------------------------
// dhtc_fifo
// Two-entry token queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhtc_fifo #(
    parameter int WIDTH = dhtc_pkg::VALUE_BITS_DEF + 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output dhtc_pkg::t_q_stat     o_stat
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/dhtc_back.sv
// ----------------------------------------------------------------------------
// dhtc_back
// Converts a queued token to the other base and sends its characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhtc_back #(
    parameter int VALUE_BITS = dhtc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire dhtc_pkg::t_q_stat     i_q_stat,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire dhtc_pkg::t_tok_flags  i_flags,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_char,
    output logic                       o_last,
    output logic                       o_bad
);

    localparam int NIBS = (VALUE_BITS + 3) / 4;
    localparam int DIGS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DW   = DIGS * 4;
    localparam int SH   = DW - NIBS * 4;
    localparam int CCW  = $clog2(VALUE_BITS + 1);
    localparam int DCW  = $clog2(DIGS + 1);

    dhtc_pkg::t_bstate     r_state, n_state;
    logic [DW-1:0]         r_dig, n_dig;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [CCW-1:0]        r_ccnt, n_ccnt;
    logic [DCW-1:0]        r_cnt, n_cnt;
    logic                  r_err, n_err;
    logic [DW-1:0]         dd;
    logic [3:0]            top_nib;
    logic                  slot_free;
    logic                  emit;
    logic [7:0]            emit_char;
    logic                  emit_last;

    logic                  r_ovalid;
    logic [7:0]            r_ochar;
    logic                  r_olast;
    logic                  r_obad;

    assign top_nib   = r_dig[DW-1 -: 4];
    assign slot_free = !r_ovalid || i_ready;

    // Double-dabble correction: every BCD digit of five or more gets three.
    always_comb begin
        dd = r_dig;
        for (int k = 0; k < DIGS; k++) begin
            if (dd[k*4 +: 4] >= 4'd5) begin
                dd[k*4 +: 4] = dd[k*4 +: 4] + 4'd3;
            end
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dhtc_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = i_flags.hex ? dhtc_pkg::B_CONV : dhtc_pkg::B_PRE0;
                end
            end
            dhtc_pkg::B_PRE0: begin
                if (slot_free) begin
                    n_state = dhtc_pkg::B_PREX;
                end
            end
            dhtc_pkg::B_PREX: begin
                if (slot_free) begin
                    n_state = dhtc_pkg::B_SKIP;
                end
            end
            dhtc_pkg::B_CONV: begin
                if (r_ccnt == CCW'(1)) begin
                    n_state = dhtc_pkg::B_SKIP;
                end
            end
            dhtc_pkg::B_SKIP: begin
                if (!(r_cnt > DCW'(1) && top_nib == 4'd0)) begin
                    n_state = dhtc_pkg::B_EMIT;
                end
            end
            dhtc_pkg::B_EMIT: begin
                if (slot_free && r_cnt == DCW'(1)) begin
                    n_state = dhtc_pkg::B_IDLE;
                end
            end
            default: n_state = dhtc_pkg::B_IDLE;
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb begin
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = dhtc_pkg::CH_ZERO;
        emit_last = 1'b0;
        n_dig     = r_dig;
        n_bin     = r_bin;
        n_ccnt    = r_ccnt;
        n_cnt     = r_cnt;
        n_err     = r_err;
        unique case (r_state)
            dhtc_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_err = i_flags.err;
                    if (i_flags.hex) begin
                        n_bin  = i_value;
                        n_dig  = '0;
                        n_ccnt = CCW'(VALUE_BITS);
                        n_cnt  = DCW'(DIGS);
                    end else begin
                        n_dig = DW'(i_value) << SH;
                        n_cnt = DCW'(NIBS);
                    end
                end
            end
            dhtc_pkg::B_PRE0: begin
                emit      = slot_free;
                emit_char = dhtc_pkg::CH_ZERO;
            end
            dhtc_pkg::B_PREX: begin
                emit      = slot_free;
                emit_char = dhtc_pkg::CH_X;
            end
            dhtc_pkg::B_CONV: begin
                n_dig  = {dd[DW-2:0], r_bin[VALUE_BITS-1]};
                n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_ccnt = r_ccnt - CCW'(1);
            end
            dhtc_pkg::B_SKIP: begin
                if (r_cnt > DCW'(1) && top_nib == 4'd0) begin
                    n_dig = r_dig << 4;
                    n_cnt = r_cnt - DCW'(1);
                end
            end
            dhtc_pkg::B_EMIT: begin
                emit      = slot_free;
                emit_char = dhtc_pkg::nib_char(top_nib);
                emit_last = (r_cnt == DCW'(1));
                if (slot_free) begin
                    n_dig = r_dig << 4;
                    n_cnt = r_cnt - DCW'(1);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhtc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_ccnt <= n_ccnt;
        r_cnt  <= n_cnt;
        r_err  <= n_err;
    end

    // Output register; it holds a character until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (emit) begin
            r_ochar <= emit_char;
            r_olast <= emit_last;
            r_obad  <= r_err;
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;
    assign o_bad   = r_obad;

endmodule

`default_nettype wire

FILE: sv/dec_hex_text_converter.sv
// Path: the last input character of a token pushes it into the queue; the back pops it and
// registers its first output character, after the double-dabble loop for hex input.
// Flow: the front takes one character per cycle while the queue is not full; the back
// handles one token at a time, with a leading-zero skip and, for hex input, a one-bit-per-cycle
// double-dabble loop, and pops the next token only after its last character is sent.
// Reset: synchronous, active low; clears the token state, queue and output valid.
// ----------------------------------------------------------------------------
// dec_hex_text_converter
// Streams ASCII number tokens in and sends them back in the other base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dec_hex_text_converter #(
    parameter int VALUE_BITS = dhtc_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = dhtc_pkg::MAX_CHARS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_char
    input  wire logic       i_s_tlast,   // in_last
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_char
    output logic            o_m_tlast,   // out_last
    output logic            o_m_tuser    // [0] bad_digit
);

    localparam int QW = VALUE_BITS + 2;

    dhtc_pkg::t_q_stat     q_stat;
    dhtc_pkg::t_tok_flags  f_flags;
    dhtc_pkg::t_tok_flags  b_flags;
    logic                  push;
    logic                  pop;
    logic [VALUE_BITS-1:0] f_value;
    logic [VALUE_BITS-1:0] b_value;
    logic [QW-1:0]         q_out;

    // Character intake and accumulation.
    dhtc_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_CHARS  (MAX_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_char   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_stat (q_stat),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_value  (f_value),
        .o_flags  (f_flags)
    );

    // Token queue.
    dhtc_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_value}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    assign b_value = q_out[VALUE_BITS-1:0];
    assign b_flags = q_out[QW-1:VALUE_BITS];

    // Conversion and character output.
    dhtc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_value  (b_value),
        .i_flags  (b_flags),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_char   (o_m_tdata),
        .o_last   (o_m_tlast),
        .o_bad    (o_m_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/dhtc_checker.sv
// ----------------------------------------------------------------------------
// dhtc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dhtc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic [7:0] i_s_tdata,
    input wire logic       i_s_tlast,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tlast,
    input wire logic       o_m_tuser
);

    logic out_xfer;
    logic in_xfer;
    logic last_is_digit;

    assign out_xfer = o_m_tvalid && i_m_tready;
    assign in_xfer  = i_s_tvalid && o_s_tready && (i_s_tlast || !i_s_tlast)
                    && (i_s_tdata == i_s_tdata);
    assign last_is_digit = (o_m_tdata >= 8'h30 && o_m_tdata <= 8'h39)
                        || (o_m_tdata >= 8'h41 && o_m_tdata <= 8'h46);

    // A stalled output character holds.
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled output changed")

    // Reset leaves no output pending.
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    // The error flag is the same on every character of one converted token.
    `ASSERT_CLKD(a_bad_const, i_clk, i_rst_n, out_xfer && !o_m_tlast |=> !o_m_tvalid || (o_m_tuser == $past(o_m_tuser)), "bad_digit changed within a token")

    // The closing character of a converted token is always a digit.
    `ASSERT_CLKD(a_last_digit, i_clk, i_rst_n, out_xfer && o_m_tlast |-> last_is_digit, "token ends on a non-digit")

    // Input is only taken while ready; in_xfer includes o_s_tready, so this check always holds.
    `ASSERT_CLKD(a_no_blind_accept, i_clk, i_rst_n, in_xfer |-> o_s_tready, "input taken while not ready")

endmodule

bind dec_hex_text_converter dhtc_checker u_dhtc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
